### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the RTL. They expand to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### src/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg
// Types, opcodes and character constants of the scrolling text console.
// ----------------------------------------------------------------------------
`default_nettype none

package stc_pkg;

    localparam logic [2:0] OP_PUT_CHAR    = 3'd0;
    localparam logic [2:0] OP_PUT_HEX     = 3'd1;
    localparam logic [2:0] OP_CLEAR       = 3'd2;
    localparam logic [2:0] OP_SET_CELL    = 3'd3;
    localparam logic [2:0] OP_BLANK_TAIL  = 3'd4;
    localparam logic [2:0] OP_READ_CELL   = 3'd5;

    localparam logic [7:0] CHR_NEWLINE    = 8'h0a;
    localparam logic [7:0] CHR_ZERO       = 8'h30;
    localparam logic [7:0] CHR_X          = 8'h78;
    localparam logic [7:0] CHR_SPACE      = 8'h20;
    localparam logic [7:0] CHR_ALPHA_BASE = 8'h37;   // 'A' - 10
    localparam logic [3:0] NIBBLE_TEN     = 4'd10;

    // Steps of the hex byte sequence: "0x", two digits, then a space.
    localparam logic [2:0] HEX_STEP_ZERO  = 3'd0;
    localparam logic [2:0] HEX_STEP_X     = 3'd1;
    localparam logic [2:0] HEX_STEP_HI    = 3'd2;
    localparam logic [2:0] HEX_STEP_LO    = 3'd3;
    localparam logic [2:0] HEX_STEP_SPACE = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_EXEC,
        S_CHAR,
        S_WRITE,
        S_READ,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] data_byte;
        logic [6:0] column;
        logic [4:0] row;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic [6:0] cursor_column;
        logic       bad_position;
    } t_out_item;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] res;
        if (nib < NIBBLE_TEN) begin
            res = CHR_ZERO + 8'(nib);
        end else begin
            res = CHR_ALPHA_BASE + 8'(nib);
        end
        return res;
    endfunction

    function automatic logic [7:0] hex_char(input logic [2:0] step, input logic [7:0] b);
        logic [7:0] res;
        unique case (step)
            HEX_STEP_ZERO: res = CHR_ZERO;
            HEX_STEP_X:    res = CHR_X;
            HEX_STEP_HI:   res = hex_digit(b[7:4]);
            HEX_STEP_LO:   res = hex_digit(b[3:0]);
            default:       res = CHR_SPACE;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

### src/stc_cell_ram.sv
// ----------------------------------------------------------------------------
// stc_cell_ram
// Single-port cell memory with a registered read; one write or read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module stc_cell_ram #(
    parameter int DEPTH = 2000,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [7:0]        i_wr_data,
    output logic      [7:0]        o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### src/scrolling_text_console.sv
// ----------------------------------------------------------------------------
// scrolling_text_console
// Character grid with a bottom-row cursor, scrolling, hex printing and
// cell access, built around one cell memory.
// ----------------------------------------------------------------------------
// The grid lives in a single-port memory addressed as a ring of rows: a
// scroll only advances the top-row pointer and marks the new bottom row as
// blank, and clear marks every row blank, so neither walks the memory. A row
// marked blank reads as zero and is zero-filled by a sweep across the whole
// row the first time a cell in it is written. Each transaction passes
// through the prepare and execute states, then, as its opcode needs, the
// character, write or read states, and ends in the response state. A newline
// always scrolls; a character that arrives on a full row first scrolls, then
// is written. Put hex byte prints its five characters in turn, each with the
// same scroll and blank-row handling. Blank row tail writes zero to each cell
// of a live row from the given column to the row's end. Everything is set by
// the one memory port, which does one cell write per cycle. The block takes
// one transaction at a time; a finished result waits in an output register
// so the next transaction can be accepted. No clearing pass is needed after
// reset.
`default_nettype none
`include "assert_macros.svh"

module scrolling_text_console #(
    parameter int GRID_WIDTH  = 80,
    parameter int GRID_HEIGHT = 25
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire stc_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output stc_pkg::t_out_item      o_out_item
);

    import stc_pkg::*;

    localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int RW         = $clog2(GRID_HEIGHT);
    localparam int CLW        = $clog2(GRID_WIDTH);
    localparam int CW         = $clog2(GRID_WIDTH + 1);

    // Control state.
    t_state           r_state,     n_state;
    logic [RW-1:0]    r_base,      n_base;
    logic [CW-1:0]    r_cursor,    n_cursor;
    logic [GRID_HEIGHT-1:0] r_row_valid, n_row_valid;
    logic             r_out_valid, n_out_valid;

    // Working registers of the transaction in flight.
    t_in_item         r_in,        n_in;
    logic [RW-1:0]    r_prow,      n_prow;
    logic             r_in_range,  n_in_range;
    logic [CLW-1:0]   r_col,       n_col;
    logic [CLW-1:0]   r_end,       n_end;
    logic [CLW-1:0]   r_tgt,       n_tgt;
    logic             r_tgt_en,    n_tgt_en;
    logic [7:0]       r_wdata,     n_wdata;
    logic [2:0]       r_chr_idx,   n_chr_idx;
    logic             r_wr_char,   n_wr_char;
    logic [7:0]       r_rd,        n_rd;
    logic             r_bad,       n_bad;
    t_out_item        r_out,       n_out;

    logic [AW-1:0]    cell_addr;
    logic             wr_en;
    logic [7:0]       wr_data;
    logic [7:0]       mem_q;
    logic [7:0]       cur_char;
    logic [RW-1:0]    bottom_row;
    logic [RW:0]      prow_sum;
    logic             chr_finish;

    stc_cell_ram #(
        .DEPTH (CELL_COUNT)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_addr    (cell_addr),
        .i_wr_data (wr_data),
        .o_rd_data (mem_q)
    );

    assign cell_addr = AW'(r_prow) * AW'(GRID_WIDTH) + AW'(r_col);
    assign wr_en     = (r_state == S_WRITE);
    assign wr_data   = (r_tgt_en && (r_col == r_tgt)) ? r_wdata : 8'h00;

    assign cur_char   = (r_in.opcode == OP_PUT_HEX) ? hex_char(r_chr_idx, r_in.data_byte)
                                                    : r_in.data_byte;
    assign bottom_row = (r_base == '0) ? RW'(GRID_HEIGHT - 1) : r_base - 1'b1;
    assign prow_sum   = (RW+1)'(r_base) + (RW+1)'(r_in.row);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_cursor    = r_cursor;
        n_row_valid = r_row_valid;
        n_out_valid = r_out_valid && !i_out_ready;
        n_in        = r_in;
        n_prow      = r_prow;
        n_in_range  = r_in_range;
        n_col       = r_col;
        n_end       = r_end;
        n_tgt       = r_tgt;
        n_tgt_en    = r_tgt_en;
        n_wdata     = r_wdata;
        n_chr_idx   = r_chr_idx;
        n_wr_char   = r_wr_char;
        n_rd        = r_rd;
        n_bad       = r_bad;
        n_out       = r_out;
        chr_finish  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_item;
                    n_state = S_PREP;
                end
            end

            S_PREP: begin
                n_in_range = (int'(r_in.column) < GRID_WIDTH) && (int'(r_in.row) < GRID_HEIGHT);
                n_col      = CLW'(r_in.column);
                if (prow_sum >= (RW+1)'(GRID_HEIGHT)) begin
                    n_prow = RW'(prow_sum - (RW+1)'(GRID_HEIGHT));
                end else begin
                    n_prow = RW'(prow_sum);
                end
                n_state = S_EXEC;
            end

            S_EXEC: begin
                n_rd      = 8'h00;
                n_bad     = 1'b0;
                n_state   = S_RESP;
                n_wr_char = 1'b0;
                n_chr_idx = HEX_STEP_ZERO;
                unique case (r_in.opcode)
                    OP_PUT_CHAR, OP_PUT_HEX: begin
                        n_state = S_CHAR;
                    end
                    OP_CLEAR: begin
                        n_row_valid = '0;
                    end
                    OP_SET_CELL: begin
                        if (!r_in_range) begin
                            n_bad = 1'b1;
                        end else begin
                            n_wdata  = r_in.data_byte;
                            n_tgt    = r_col;
                            n_tgt_en = 1'b1;
                            n_state  = S_WRITE;
                            if (r_row_valid[r_prow]) begin
                                n_end = r_col;
                            end else begin
                                // A blank row is zero-filled around the new cell.
                                n_col = '0;
                                n_end = CLW'(GRID_WIDTH - 1);
                            end
                        end
                    end
                    OP_BLANK_TAIL: begin
                        if (!r_in_range) begin
                            n_bad = 1'b1;
                        end else if (r_row_valid[r_prow]) begin
                            n_tgt_en = 1'b0;
                            n_end    = CLW'(GRID_WIDTH - 1);
                            n_state  = S_WRITE;
                        end
                    end
                    OP_READ_CELL: begin
                        if (!r_in_range) begin
                            n_bad = 1'b1;
                        end else if (r_row_valid[r_prow]) begin
                            n_state = S_READ;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            S_CHAR: begin
                if ((cur_char == CHR_NEWLINE) || (int'(r_cursor) >= GRID_WIDTH)) begin
                    // Scroll: the old top row becomes the new, blank bottom row.
                    n_row_valid[r_base] = 1'b0;
                    n_base   = (r_base == RW'(GRID_HEIGHT - 1)) ? '0 : r_base + 1'b1;
                    n_cursor = '0;
                    if (cur_char == CHR_NEWLINE) begin
                        chr_finish = 1'b1;
                    end
                end else begin
                    n_prow    = bottom_row;
                    n_wdata   = cur_char;
                    n_tgt     = CLW'(r_cursor);
                    n_tgt_en  = 1'b1;
                    n_wr_char = 1'b1;
                    n_cursor  = r_cursor + 1'b1;
                    n_state   = S_WRITE;
                    if (r_row_valid[bottom_row]) begin
                        n_col = CLW'(r_cursor);
                        n_end = CLW'(r_cursor);
                    end else begin
                        n_col = '0;
                        n_end = CLW'(GRID_WIDTH - 1);
                    end
                end
            end

            S_WRITE: begin
                if (r_col == r_end) begin
                    n_row_valid[r_prow] = 1'b1;
                    if (r_wr_char) begin
                        chr_finish = 1'b1;
                    end else begin
                        n_state = S_RESP;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end

            S_READ: begin
                n_rd    = mem_q;
                n_state = S_RESP;
            end

            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.read_data     = r_rd;
                    n_out.cursor_column = 7'(r_cursor);
                    n_out.bad_position  = r_bad;
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A character is complete; a hex byte moves on to its next character.
        if (chr_finish) begin
            if ((r_in.opcode == OP_PUT_HEX) && (r_chr_idx != HEX_STEP_SPACE)) begin
                n_chr_idx = r_chr_idx + 1'b1;
                n_state   = S_CHAR;
            end else begin
                n_state   = S_RESP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_cursor    <= '0;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_cursor    <= n_cursor;
            r_row_valid <= n_row_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in       <= n_in;
        r_prow     <= n_prow;
        r_in_range <= n_in_range;
        r_col      <= n_col;
        r_end      <= n_end;
        r_tgt      <= n_tgt;
        r_tgt_en   <= n_tgt_en;
        r_wdata    <= n_wdata;
        r_chr_idx  <= n_chr_idx;
        r_wr_char  <= n_wr_char;
        r_rd       <= n_rd;
        r_bad      <= n_bad;
        r_out      <= n_out;
    end

    `ASSERT_ALWAYS(a_base_range, i_clk, i_rst_n, int'(r_base) < GRID_HEIGHT, "top row out of range")
    `ASSERT_ALWAYS(a_cursor_range, i_clk, i_rst_n, int'(r_cursor) <= GRID_WIDTH, "cursor past end")
    `ASSERT_IMPLY(a_sweep_bound, i_clk, i_rst_n, r_state == S_WRITE, r_col <= r_end, "sweep overran")

endmodule

`default_nettype wire
